FILE: rtl/crc8fc_pkg.sv
// ----------------------------------------------------------------------------
// crc8fc_pkg
// Shared types, codes and helper functions for the CRC-8 frame checker.
// ----------------------------------------------------------------------------
package crc8fc_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int INDEX_W    = 4;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_WORDS  = 3;
    localparam int LANES      = WORD_W / BYTE_W;

    // CRC-8 polynomial x^8 + x^2 + x + 1
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

    // Frame kinds
    localparam logic [KIND_W-1:0] KIND_SOUND    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POSITION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIGHT    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TIMING   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CRC_BAD   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_WRONG_CMD = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LASER_ON  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LASER_OFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMING    = 3'd5;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_VOLUME    = 8'd1;
    localparam logic [BYTE_W-1:0] RST_POSITION  = 8'd2;
    localparam logic [BYTE_W-1:0] RST_LIGHT     = 8'd3;
    localparam logic [BYTE_W-1:0] RST_LASER_ON  = 8'd4;
    localparam logic [BYTE_W-1:0] RST_LASER_OFF = 8'd5;
    localparam logic [BYTE_W-1:0] RST_TIMING    = 8'd6;

    // Command register bank
    typedef struct packed {
        logic [BYTE_W-1:0] volume;
        logic [BYTE_W-1:0] position;
        logic [BYTE_W-1:0] light;
        logic [BYTE_W-1:0] laser_on;
        logic [BYTE_W-1:0] laser_off;
        logic [BYTE_W-1:0] timing;
    } cmd_regs_t;

    // Index of the CRC byte for each kind (frame length minus one)
    function automatic logic [INDEX_W-1:0] crc_index(input logic [KIND_W-1:0] kind);
        logic [INDEX_W-1:0] idx;
        case (kind)
            KIND_SOUND:    idx = 4'd5;
            KIND_POSITION: idx = 4'd9;
            KIND_LIGHT:    idx = 4'd1;
            KIND_TIMING:   idx = 4'd13;
            default:       idx = 4'd13;
        endcase
        return idx;
    endfunction

    // One byte through the MSB-first CRC-8, eight shift steps unrolled
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

    // Command check for the frame kind
    function automatic logic cmd_match(input logic [KIND_W-1:0] kind,
                                       input logic [BYTE_W-1:0] cmd,
                                       input cmd_regs_t regs);
        logic ok;
        case (kind)
            KIND_SOUND:    ok = (cmd == regs.volume);
            KIND_POSITION: ok = (cmd == regs.position);
            KIND_LIGHT:    ok = (cmd == regs.light) || (cmd == regs.laser_on)
                                || (cmd == regs.laser_off);
            KIND_TIMING:   ok = (cmd == regs.timing);
            default:       ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

FILE: rtl/crc8_message_frame_checker_core.sv
// The status appears in the result register in the cycle after its byte transfer.
// Throughput: one byte per cycle unless stalled; each byte is taken in a single pass through the
//   unrolled CRC-8 step and the frame bookkeeping, so the next byte may follow at once.
// Input ready drops only while a result waits and the output side is stalled.
// Reset (rst_n low, asynchronous): no frame open, command registers at defaults,
//   result register empty.
// ----------------------------------------------------------------------------
// crc8_message_frame_checker_core
// Byte-serial frame checker: collects command and payload words, runs CRC-8
// over the frame and reports at most one status per frame.
// ----------------------------------------------------------------------------
module crc8_message_frame_checker_core
    import crc8fc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration write port
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,

    // Byte input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 frame_start,
    input  logic                 frame_end,
    input  logic [KIND_W-1:0]    func,

    // Status output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [BYTE_W-1:0]    command_code,
    output logic [WORD_W-1:0]    word_a,
    output logic [WORD_W-1:0]    word_b,
    output logic [WORD_W-1:0]    word_c
);

    // Command registers
    cmd_regs_t cmd_regs_reg;

    // Frame state
    logic [BYTE_W-1:0]  running_crc_reg, running_crc_next;
    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [KIND_W-1:0]  frame_kind_reg, frame_kind_next;
    logic [BYTE_W-1:0]  first_byte_reg, first_byte_next;
    logic [WORD_W-1:0]  payload_reg [NUM_WORDS];
    logic [WORD_W-1:0]  payload_next [NUM_WORDS];
    logic               reported_reg, reported_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0]   cmd_out_reg;
    logic [WORD_W-1:0]   word_out_reg [NUM_WORDS];

    logic               in_xfer;
    logic [INDEX_W-1:0] pay_pos;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Configuration writes; out-of-range indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_regs_reg.volume    <= RST_VOLUME;
            cmd_regs_reg.position  <= RST_POSITION;
            cmd_regs_reg.light     <= RST_LIGHT;
            cmd_regs_reg.laser_on  <= RST_LASER_ON;
            cmd_regs_reg.laser_off <= RST_LASER_OFF;
            cmd_regs_reg.timing    <= RST_TIMING;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_VOLUME:    cmd_regs_reg.volume    <= cfg_data;
                REG_POSITION:  cmd_regs_reg.position  <= cfg_data;
                REG_LIGHT:     cmd_regs_reg.light     <= cfg_data;
                REG_LASER_ON:  cmd_regs_reg.laser_on  <= cfg_data;
                REG_LASER_OFF: cmd_regs_reg.laser_off <= cfg_data;
                REG_TIMING:    cmd_regs_reg.timing    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Per-byte frame update
    always_comb
    begin
        running_crc_next = running_crc_reg;
        byte_index_next  = byte_index_reg;
        frame_kind_next  = frame_kind_reg;
        first_byte_next  = first_byte_reg;
        reported_next    = reported_reg;
        pay_pos          = '0;
        for (int w = 0; w < NUM_WORDS; w++)
            payload_next[w] = payload_reg[w];
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;

        if (in_xfer)
        begin
            out_valid_next = 1'b0;
            // frame start drops any open frame
            if (frame_start)
            begin
                frame_kind_next  = func;
                running_crc_next = '0;
                byte_index_next  = '0;
                first_byte_next  = '0;
                reported_next    = 1'b0;
                for (int w = 0; w < NUM_WORDS; w++)
                    payload_next[w] = '0;
            end

            if (!reported_next)
            begin
                if (byte_index_next >= crc_index(frame_kind_next))
                begin
                    // CRC byte: checks in order mismatch, then command
                    out_valid_next = 1'b1;
                    reported_next  = 1'b1;
                    if (running_crc_next != rx_byte)
                        status_next = ST_CRC_BAD;
                    else if (!cmd_match(frame_kind_next, first_byte_next, cmd_regs_reg))
                        status_next = ST_WRONG_CMD;
                    else
                        status_next = ST_OK;
                end
                else
                begin
                    running_crc_next = crc8_byte(running_crc_next, rx_byte);
                    if (byte_index_next == '0)
                        first_byte_next = rx_byte;
                    else
                    begin
                        // position of the current byte within the payload
                        pay_pos = byte_index_next - 4'd1;
                        for (int w = 0; w < NUM_WORDS; w++)
                            for (int l = 0; l < LANES; l++)
                                if (pay_pos[3:2] == w[1:0] && pay_pos[1:0] == l[1:0])
                                    payload_next[w][l*BYTE_W +: BYTE_W] = rx_byte;
                    end
                    byte_index_next = byte_index_next + 4'd1;
                    // early end closes the frame as short
                    if (frame_end)
                    begin
                        out_valid_next = 1'b1;
                        reported_next  = 1'b1;
                        status_next    = ST_SHORT;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= '0;
            byte_index_reg  <= '0;
            frame_kind_reg  <= KIND_SOUND;
            first_byte_reg  <= '0;
            reported_reg    <= 1'b1;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            for (int w = 0; w < NUM_WORDS; w++)
                payload_reg[w] <= '0;
        end
        else
        begin
            running_crc_reg <= running_crc_next;
            byte_index_reg  <= byte_index_next;
            frame_kind_reg  <= frame_kind_next;
            first_byte_reg  <= first_byte_next;
            reported_reg    <= reported_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            for (int w = 0; w < NUM_WORDS; w++)
                payload_reg[w] <= payload_next[w];
        end
    end

    // Result payload, loaded when a status is produced
    always_ff @(posedge clk)
    begin
        if (in_xfer && out_valid_next)
        begin
            cmd_out_reg <= first_byte_next;
            for (int w = 0; w < NUM_WORDS; w++)
                word_out_reg[w] <= payload_next[w];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign command_code = cmd_out_reg;
    assign word_a       = word_out_reg[0];
    assign word_b       = word_out_reg[1];
    assign word_c       = word_out_reg[2];

    // Checks
    a_idle_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !frame_start && reported_reg |=> !out_valid_reg)
        else $error("byte outside a frame produced a result");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= 4'd13)
        else $error("byte index past the longest frame");

    a_result_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> reported_reg)
        else $error("result pending while a frame is still open");

    a_start_takes_command: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && frame_start && !frame_end |=> byte_index_reg == 4'd1 && !out_valid_reg)
        else $error("frame start byte not taken as command");

endmodule

FILE: tb/sv/crc8_message_frame_checker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_message_frame_checker_core_tb
// Self-checking bench for the CRC-8 frame checker. Frames of every kind are
// sent byte by byte with random gaps and output stalls. A tracker predicts
// the status, command and payload words reported for each frame. Command
// registers are reloaded between phases.
// ----------------------------------------------------------------------------
import crc8fc_pkg::*;

// One reported frame as seen on the status channel
typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   command_code;
    logic [WORD_W-1:0]   word_a;
    logic [WORD_W-1:0]   word_b;
    logic [WORD_W-1:0]   word_c;
} frame_report_t;

// Frame tracker: follows the byte stream and queues the reports it implies
class frame_status_tracker;
    logic [BYTE_W-1:0] cmd_reg [6];
    logic [BYTE_W-1:0] crc_acc;
    int                pos;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] cmd_byte;
    logic [WORD_W-1:0] words [NUM_WORDS];
    bit                open;
    frame_report_t     pending_reports [$];
    int                mismatches;

    function new();
        cmd_reg[REG_VOLUME]    = RST_VOLUME;
        cmd_reg[REG_POSITION]  = RST_POSITION;
        cmd_reg[REG_LIGHT]     = RST_LIGHT;
        cmd_reg[REG_LASER_ON]  = RST_LASER_ON;
        cmd_reg[REG_LASER_OFF] = RST_LASER_OFF;
        cmd_reg[REG_TIMING]    = RST_TIMING;
        crc_acc    = '0;
        pos        = 0;
        kind       = KIND_SOUND;
        cmd_byte   = '0;
        foreach (words[i]) words[i] = '0;
        open       = 1'b0;
        mismatches = 0;
    endfunction

    // Indexes past the timing register are not decoded
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
        if (idx <= REG_TIMING)
            cmd_reg[idx] = data;
    endfunction

    function int frame_length(logic [KIND_W-1:0] k);
        case (k)
            KIND_SOUND:    return 6;
            KIND_POSITION: return 10;
            KIND_LIGHT:    return 2;
            default:       return 14;
        endcase
    endfunction

    // Bit-serial CRC-8, data MSB first
    function logic [BYTE_W-1:0] crc_step(logic [BYTE_W-1:0] c, logic [BYTE_W-1:0] d);
        logic fb;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = c[BYTE_W-1] ^ d[i];
            c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function bit command_accepted(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] c);
        case (k)
            KIND_SOUND:    return c == cmd_reg[REG_VOLUME];
            KIND_POSITION: return c == cmd_reg[REG_POSITION];
            KIND_LIGHT:    return c == cmd_reg[REG_LIGHT] || c == cmd_reg[REG_LASER_ON]
                                  || c == cmd_reg[REG_LASER_OFF];
            default:       return c == cmd_reg[REG_TIMING];
        endcase
    endfunction

    // Mostly the code the kind expects, sometimes anything
    function logic [BYTE_W-1:0] pick_command(logic [KIND_W-1:0] k);
        if ($urandom_range(0, 99) >= 75)
            return BYTE_W'($urandom);
        case (k)
            KIND_SOUND:    return cmd_reg[REG_VOLUME];
            KIND_POSITION: return cmd_reg[REG_POSITION];
            KIND_LIGHT:    return cmd_reg[REG_LIGHT + $urandom_range(0, 2)];
            default:       return cmd_reg[REG_TIMING];
        endcase
    endfunction

    function void queue_report(logic [STATUS_W-1:0] st);
        frame_report_t r;
        r.status       = st;
        r.command_code = cmd_byte;
        r.word_a       = words[0];
        r.word_b       = words[1];
        r.word_c       = words[2];
        pending_reports.push_back(r);
        open = 1'b0;
    endfunction

    // Returns 1 when the byte was consumed by an open frame
    function bit take_byte(logic [BYTE_W-1:0] b, bit s, bit e, logic [KIND_W-1:0] f);
        int p;
        if (s) begin
            kind     = f;
            crc_acc  = '0;
            pos      = 0;
            cmd_byte = '0;
            foreach (words[i]) words[i] = '0;
            open     = 1'b1;
        end
        if (!open)
            return 1'b0;
        // CRC byte: checks in order crc, then command
        if (pos + 1 >= frame_length(kind)) begin
            if (crc_acc != b)
                queue_report(ST_CRC_BAD);
            else if (!command_accepted(kind, cmd_byte))
                queue_report(ST_WRONG_CMD);
            else
                queue_report(ST_OK);
            return 1'b1;
        end
        crc_acc = crc_step(crc_acc, b);
        if (pos == 0)
            cmd_byte = b;
        else begin
            p = pos - 1;
            words[p / 4][(p % 4) * 8 +: 8] = b;
        end
        pos++;
        if (e)
            queue_report(ST_SHORT);
        return 1'b1;
    endfunction

    function void compare(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function void match_report(frame_report_t got);
        frame_report_t want;
        if (pending_reports.size() == 0) begin
            $error("unexpected status transfer: status %0d, command_code %0h",
                   got.status, got.command_code);
            mismatches++;
            return;
        end
        want = pending_reports.pop_front();
        compare("status", WORD_W'(want.status), WORD_W'(got.status));
        compare("command_code", WORD_W'(want.command_code), WORD_W'(got.command_code));
        compare("word_a", want.word_a, got.word_a);
        compare("word_b", want.word_b, got.word_b);
        compare("word_c", want.word_c, got.word_c);
    endfunction

    function int pending();
        return pending_reports.size();
    endfunction
endclass

module crc8_message_frame_checker_core_tb;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 212;

    // Payload fill patterns
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZEROS  = 2;

    // Register indexes beyond the decoded range
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 frame_start;
    logic                 frame_end;
    logic [KIND_W-1:0]    func;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [BYTE_W-1:0]    command_code;
    logic [WORD_W-1:0]    word_a;
    logic [WORD_W-1:0]    word_b;
    logic [WORD_W-1:0]    word_c;

    frame_status_tracker tracker;
    bit                  steady;
    int                  taken_items;
    int                  stall_cycles = 0;

    crc8_message_frame_checker_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .frame_start  (frame_start),
        .frame_end    (frame_end),
        .func         (func),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .command_code (command_code),
        .word_a       (word_a),
        .word_b       (word_b),
        .word_c       (word_c)
    );

    always #5 clk = ~clk;

    // Output side: random stalls except in the steady stretch
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= 17);
    end

    // Status monitor and stall watchdog; sampled mid-cycle
    always @(negedge clk)
    begin
        frame_report_t got;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got.status       = status;
                got.command_code = command_code;
                got.word_a       = word_a;
                got.word_b       = word_b;
                got.word_c       = word_c;
                tracker.match_report(got);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // One byte transfer, with an optional idle gap ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit s, input bit e,
                             input logic [KIND_W-1:0] f);
        int gap;
        bit took;
        gap = 0;
        if (!steady)
            while ($urandom_range(0, 99) < 17)
                gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= s;
        frame_end   <= e;
        func        <= f;
        do begin
            @(negedge clk);
            took = in_ready;
            if (took && tracker.take_byte(b, s, e, f))
                taken_items++;
            @(posedge clk);
        end while (!took);
    endtask

    // Builds a frame and sends the first cut bytes (all when cut is 0)
    task automatic send_frame(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] cmd,
                              input int fill, input bit bad_crc, input int cut,
                              input bit end_early, input bit end_on_crc, input int trailing);
        logic [BYTE_W-1:0] frame_bytes [14];
        logic [BYTE_W-1:0] c;
        int                len;
        int                n;
        bit                mark_end;
        len = tracker.frame_length(k);
        frame_bytes[0] = cmd;
        for (int i = 1; i < len - 1; i++)
            frame_bytes[i] = (fill == FILL_ONES)  ? 8'hFF :
                             (fill == FILL_ZEROS) ? 8'h00 : BYTE_W'($urandom);
        c = '0;
        for (int i = 0; i < len - 1; i++)
            c = tracker.crc_step(c, frame_bytes[i]);
        frame_bytes[len-1] = bad_crc ? (c ^ BYTE_W'($urandom_range(1, 255))) : c;
        n = (cut > 0 && cut < len) ? cut : len;
        for (int i = 0; i < n; i++) begin
            mark_end = (i == n - 1) && ((n < len) ? end_early : end_on_crc);
            send_byte(frame_bytes[i], i == 0, mark_end,
                      (i == 0) ? k : KIND_W'($urandom_range(0, 3)));
        end
        // bytes past the CRC byte are dropped by the block
        repeat (trailing)
            send_byte(BYTE_W'($urandom), 1'b0, 1'($urandom_range(0, 1)),
                      KIND_W'($urandom_range(0, 3)));
    endtask

    // Stop sending and let every queued report drain
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cmd(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    // Register settings for each random phase
    task automatic load_phase(input int ph);
        logic [BYTE_W-1:0] v;
        case (ph)
            1: begin
                for (int i = REG_VOLUME; i <= REG_TIMING; i++)
                    write_cmd(CFG_IDX_W'(i), 8'h00);
                write_cmd(REG_SPARE_LO, BYTE_W'($urandom));
                write_cmd(REG_SPARE_HI, BYTE_W'($urandom));
            end
            2: begin
                for (int i = REG_VOLUME; i <= REG_TIMING; i++)
                    write_cmd(CFG_IDX_W'(i), 8'hFF);
            end
            3: begin
                // two light codes share a value
                v = BYTE_W'($urandom);
                write_cmd(REG_LIGHT, v);
                write_cmd(REG_LASER_ON, v);
                write_cmd(REG_LASER_OFF, BYTE_W'($urandom));
                write_cmd(REG_VOLUME, BYTE_W'($urandom));
                write_cmd(REG_POSITION, BYTE_W'($urandom));
                write_cmd(REG_TIMING, BYTE_W'($urandom));
            end
            default: begin
                for (int i = REG_VOLUME; i <= REG_TIMING; i++)
                    write_cmd(CFG_IDX_W'(i), BYTE_W'($urandom));
            end
        endcase
        cfg_write <= 1'b0;
    endtask

    task automatic run_random(input int target);
        int                sel;
        int                len;
        logic [KIND_W-1:0] k;
        while (taken_items < target) begin
            sel = $urandom_range(0, 99);
            k   = KIND_W'($urandom_range(0, 3));
            len = tracker.frame_length(k);
            if (sel < 70)
                send_frame(k, tracker.pick_command(k), FILL_RANDOM,
                           $urandom_range(0, 99) < 15, 0, 1'b0, 1'($urandom_range(0, 1)),
                           ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 2)) : 0);
            else if (sel < 82)
                // early end
                send_frame(k, tracker.pick_command(k), FILL_RANDOM, 1'b0,
                           int'($urandom_range(1, len - 1)), 1'b1, 1'b0, 0);
            else if (sel < 90)
                // left open, the next start drops it
                send_frame(k, tracker.pick_command(k), FILL_RANDOM, 1'b0,
                           int'($urandom_range(1, len - 1)), 1'b0, 1'b0, 0);
            else
                repeat ($urandom_range(1, 4))
                    send_byte(BYTE_W'($urandom), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 3) == 0, KIND_W'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        rx_byte      = '0;
        frame_start  = 1'b0;
        frame_end    = 1'b0;
        func         = '0;
        steady       = 1'b0;
        taken_items  = 0;
        tracker      = new();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at reset register values
        send_byte(8'hA5, 1'b0, 1'b0, KIND_SOUND);
        send_frame(KIND_LIGHT, RST_LIGHT, FILL_RANDOM, 1'b0, 0, 1'b0, 1'b0, 0);
        send_frame(KIND_LIGHT, RST_LASER_ON, FILL_RANDOM, 1'b0, 0, 1'b0, 1'b1, 1);
        send_frame(KIND_LIGHT, RST_LASER_OFF, FILL_RANDOM, 1'b0, 0, 1'b0, 1'b0, 0);
        send_frame(KIND_LIGHT, 8'h00, FILL_RANDOM, 1'b0, 0, 1'b0, 1'b0, 0);
        // bad CRC outranks the wrong command
        send_frame(KIND_SOUND, 8'hFF, FILL_ONES, 1'b1, 0, 1'b0, 1'b0, 0);
        send_frame(KIND_POSITION, RST_POSITION, FILL_ZEROS, 1'b0, 3, 1'b1, 1'b0, 0);
        send_frame(KIND_TIMING, RST_TIMING, FILL_RANDOM, 1'b0, 1, 1'b1, 1'b0, 0);
        send_frame(KIND_SOUND, RST_VOLUME, FILL_RANDOM, 1'b0, 2, 1'b0, 1'b0, 0);
        send_frame(KIND_LIGHT, RST_LIGHT, FILL_RANDOM, 1'b0, 0, 1'b0, 1'b0, 0);

        // Random phases, registers reloaded while idle
        for (int ph = 1; ph <= 4; ph++) begin
            wait_drained();
            load_phase(ph);
            steady = (ph == 2);
            run_random(taken_items + PHASE_ITEMS);
        end
        steady = 1'b0;
        wait_drained();

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
rtl/crc8fc_pkg.sv
rtl/crc8_message_frame_checker_core.sv
tb/sv/crc8_message_frame_checker_core_tb.sv
